// ===== design/epsc_pkg.sv =====
package epsc_pkg;

    // Build-time configuration
    localparam int COUNT_WIDTH    = 16;
    localparam int COEF_FRAC_BITS = 16;

    // Fixed formats
    localparam int VEL_FRAC    = 12;
    localparam int VEL_W       = 24;
    localparam int ERR_W       = VEL_W + 1;
    localparam int COEF_W      = 24;
    localparam int ACC_W       = 22;
    localparam int DUTY_W      = 8;
    localparam int DRIVE_W     = DUTY_W + 1;
    localparam int DRIVE_LIMIT = 255;
    localparam int ACC_LIMIT   = DRIVE_LIMIT << VEL_FRAC;

    localparam int VEL_RSHIFT = (COEF_FRAC_BITS >= VEL_FRAC) ? (COEF_FRAC_BITS - VEL_FRAC) : 0;
    localparam int VEL_LSHIFT = (COEF_FRAC_BITS < VEL_FRAC) ? (VEL_FRAC - COEF_FRAC_BITS) : 0;

    // Shared multiplier: count or error times scale or coefficient
    localparam int MUL_A_W = (COUNT_WIDTH > ERR_W) ? COUNT_WIDTH : ERR_W;
    localparam int MUL_B_W = COEF_W + 1;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int VW_W    = MUL_P_W + VEL_LSHIFT;
    localparam int SUM_W   = MUL_P_W + 2;
    localparam int ACC_SUM_W = SUM_W + 1;

    // Configuration port
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;
    localparam int REG_IDX_W  = CFG_ADDR_W - 2;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_COEF_Q0        = 3'd0,
        REG_COEF_Q1        = 3'd1,
        REG_COEF_Q2        = 3'd2,
        REG_VELOCITY_SCALE = 3'd3,
        REG_REVERSE_DIR    = 3'd4
    } reg_idx_t;

    // Request kinds
    localparam logic REQ_EDGE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef enum logic [1:0] {
        MUL_VEL = 2'd0,
        MUL_Q0  = 2'd1,
        MUL_Q1  = 2'd2,
        MUL_Q2  = 2'd3
    } mul_sel_t;

    typedef enum logic [1:0] {
        SUM_HOLD = 2'd0,
        SUM_LOAD = 2'd1,
        SUM_ADD  = 2'd2
    } sum_op_t;

    typedef struct packed {
        logic [COEF_W-1:0] coef_q0;
        logic [COEF_W-1:0] coef_q1;
        logic [COEF_W-1:0] coef_q2;
        logic [COEF_W-1:0] velocity_scale;
        logic              reverse_dir;
    } cfg_t;

    typedef struct packed {
        logic     edge_en;
        logic     tick_en;
        mul_sel_t mul_sel;
        logic     vel_en;
        sum_op_t  sum_op;
        logic     acc_en;
        logic     out_load;
    } dp_cmd_t;

endpackage

// ===== design/epsc_if.sv =====
interface epsc_req_if import epsc_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    req_type;
    logic                    enc_a;
    logic                    enc_b;
    logic signed [VEL_W-1:0] setpoint;

    modport source (output valid, req_type, enc_a, enc_b, setpoint, input ready);
    modport sink (input valid, req_type, enc_a, enc_b, setpoint, output ready);
endinterface

interface epsc_rsp_if import epsc_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [DUTY_W-1:0]         duty;
    logic                      dir_in1;
    logic                      dir_in2;
    logic signed [DRIVE_W-1:0] drive;
    logic signed [VEL_W-1:0]   measured_velocity;

    modport source (output valid, duty, dir_in1, dir_in2, drive, measured_velocity, input ready);
    modport sink (input valid, duty, dir_in1, dir_in2, drive, measured_velocity, output ready);
endinterface

// ===== design/epsc_cfg.sv =====
module epsc_cfg import epsc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    logic [COEF_W-1:0] q0_reg, q0_next;
    logic [COEF_W-1:0] q1_reg, q1_next;
    logic [COEF_W-1:0] q2_reg, q2_next;
    logic [COEF_W-1:0] scale_reg, scale_next;
    logic              rev_reg, rev_next;
    logic              wr_en;
    reg_idx_t          idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);

    always_comb
    begin
        q0_next    = q0_reg;
        q1_next    = q1_reg;
        q2_next    = q2_reg;
        scale_next = scale_reg;
        rev_next   = rev_reg;
        if (wr_en)
        begin
            case (idx)
                REG_COEF_Q0:        q0_next    = pwdata[COEF_W-1:0];
                REG_COEF_Q1:        q1_next    = pwdata[COEF_W-1:0];
                REG_COEF_Q2:        q2_next    = pwdata[COEF_W-1:0];
                REG_VELOCITY_SCALE: scale_next = pwdata[COEF_W-1:0];
                REG_REVERSE_DIR:    rev_next   = pwdata[0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q0_reg    <= '0;
            q1_reg    <= '0;
            q2_reg    <= '0;
            scale_reg <= '0;
            rev_reg   <= 1'b0;
        end
        else
        begin
            q0_reg    <= q0_next;
            q1_reg    <= q1_next;
            q2_reg    <= q2_next;
            scale_reg <= scale_next;
            rev_reg   <= rev_next;
        end
    end

    always_comb
    begin
        case (idx)
            REG_COEF_Q0:        prdata = CFG_DATA_W'(q0_reg);
            REG_COEF_Q1:        prdata = CFG_DATA_W'(q1_reg);
            REG_COEF_Q2:        prdata = CFG_DATA_W'(q2_reg);
            REG_VELOCITY_SCALE: prdata = CFG_DATA_W'(scale_reg);
            REG_REVERSE_DIR:    prdata = CFG_DATA_W'(rev_reg);
            default:            prdata = '0;
        endcase
    end

    assign cfg.coef_q0        = q0_reg;
    assign cfg.coef_q1        = q1_reg;
    assign cfg.coef_q2        = q2_reg;
    assign cfg.velocity_scale = scale_reg;
    assign cfg.reverse_dir    = rev_reg;

endmodule

// ===== design/epsc_ctrl.sv =====
module epsc_ctrl import epsc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic    in_req_type,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    output dp_cmd_t cmd
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_VEL  = 8'b0000_0010,
        S_ERR  = 8'b0000_0100,
        S_M1   = 8'b0000_1000,
        S_M2   = 8'b0001_0000,
        S_M3   = 8'b0010_0000,
        S_ACC  = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.mul_sel  = MUL_VEL;
        cmd.sum_op   = SUM_HOLD;
        case (state_reg)
            S_IDLE:
            begin
                cmd.edge_en = accept && (in_req_type == REQ_EDGE);
                cmd.tick_en = accept && (in_req_type == REQ_TICK);
                if (cmd.tick_en)
                    state_next = S_VEL;
            end
            S_VEL:
            begin
                cmd.mul_sel = MUL_VEL;
                state_next  = S_ERR;
            end
            S_ERR:
            begin
                cmd.vel_en  = 1'b1;
                cmd.mul_sel = MUL_Q1;
                state_next  = S_M1;
            end
            S_M1:
            begin
                cmd.sum_op  = SUM_LOAD;
                cmd.mul_sel = MUL_Q2;
                state_next  = S_M2;
            end
            S_M2:
            begin
                cmd.sum_op  = SUM_ADD;
                cmd.mul_sel = MUL_Q0;
                state_next  = S_M3;
            end
            S_M3:
            begin
                cmd.sum_op = SUM_ADD;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc_en = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // hold until the result register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_tick_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_req_type == REQ_TICK) |=> (state_reg == S_VEL))
        else $error("tick request did not start the multiply sequence");

    a_out_blocked_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && out_valid_reg && !out_ready) |=> (state_reg == S_OUT))
        else $error("result overwritten while previous one pending");

endmodule

// ===== design/epsc_dp.sv =====
module epsc_dp import epsc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  dp_cmd_t                   cmd,
    input  cfg_t                      cfg,
    input  logic                      enc_a,
    input  logic                      enc_b,
    input  logic signed [VEL_W-1:0]   setpoint,
    output logic [DUTY_W-1:0]         duty,
    output logic                      dir_in1,
    output logic                      dir_in2,
    output logic signed [DRIVE_W-1:0] drive,
    output logic signed [VEL_W-1:0]   measured_velocity
);

    // Controller state
    logic signed [COUNT_WIDTH-1:0] count_reg, count_next;
    logic signed [ERR_W-1:0]       err_last_reg, err_last_next;
    logic signed [ERR_W-1:0]       err_prev_reg, err_prev_next;
    logic signed [ACC_W-1:0]       acc_reg, acc_next;

    // Working registers
    logic signed [VEL_W-1:0]   target_reg, target_next;
    logic signed [ERR_W-1:0]   err_reg, err_next;
    logic signed [VEL_W-1:0]   vel_reg, vel_next;
    logic signed [MUL_P_W-1:0] prod_reg, prod_next;
    logic signed [SUM_W-1:0]   sum_reg, sum_next;

    // Result registers
    logic [DUTY_W-1:0]         duty_reg, duty_next;
    logic                      dir1_reg, dir1_next;
    logic                      dir2_reg, dir2_next;
    logic signed [DRIVE_W-1:0] drive_reg, drive_next;
    logic signed [VEL_W-1:0]   mvel_reg, mvel_next;

    logic                        step_up;
    logic                        at_max;
    logic                        at_min;
    logic signed [MUL_A_W-1:0]   mul_a;
    logic signed [MUL_B_W-1:0]   mul_b;
    logic signed [VW_W-1:0]      vel_wide;
    logic                        vel_ovf;
    logic signed [VEL_W-1:0]     vel_sat;
    logic signed [SUM_W-1:0]     inc;
    logic signed [ACC_SUM_W-1:0] acc_sum;
    logic signed [ACC_SUM_W-1:0] acc_hi;
    logic signed [ACC_SUM_W-1:0] acc_lo;
    logic signed [ACC_W-1:0]     acc_clamped;
    logic [ACC_W-1:0]            acc_mag;
    logic [DUTY_W-1:0]           duty_val;
    logic                        drv_neg;

    // Edge counter
    assign step_up = (enc_a != enc_b) ^ cfg.reverse_dir;
    assign at_max  = (count_reg == {1'b0, {(COUNT_WIDTH-1){1'b1}}});
    assign at_min  = (count_reg == {1'b1, {(COUNT_WIDTH-1){1'b0}}});

    always_comb
    begin
        count_next = count_reg;
        if (cmd.vel_en)
            count_next = '0;
        else if (cmd.edge_en)
        begin
            if (step_up && !at_max)
                count_next = count_reg + COUNT_WIDTH'(1);
            else if (!step_up && !at_min)
                count_next = count_reg - COUNT_WIDTH'(1);
        end
    end

    // Shared multiplier
    always_comb
    begin
        case (cmd.mul_sel)
            MUL_VEL:
            begin
                mul_a = MUL_A_W'(count_reg);
                mul_b = signed'({1'b0, cfg.velocity_scale});
            end
            MUL_Q0:
            begin
                mul_a = MUL_A_W'(err_reg);
                mul_b = MUL_B_W'(signed'(cfg.coef_q0));
            end
            MUL_Q1:
            begin
                mul_a = MUL_A_W'(err_last_reg);
                mul_b = MUL_B_W'(signed'(cfg.coef_q1));
            end
            MUL_Q2:
            begin
                mul_a = MUL_A_W'(err_prev_reg);
                mul_b = MUL_B_W'(signed'(cfg.coef_q2));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // Velocity: rescale to 12 fraction bits and saturate
    assign vel_wide = (VW_W'(prod_reg) <<< VEL_LSHIFT) >>> VEL_RSHIFT;
    assign vel_ovf  = !((&vel_wide[VW_W-1:VEL_W-1]) || !(|vel_wide[VW_W-1:VEL_W-1]));
    assign vel_sat  = vel_ovf ? (vel_wide[VW_W-1] ? {1'b1, {(VEL_W-1){1'b0}}}
                                                  : {1'b0, {(VEL_W-1){1'b1}}})
                              : vel_wide[VEL_W-1:0];

    assign target_next = cmd.tick_en ? setpoint : target_reg;
    assign vel_next    = cmd.vel_en ? vel_sat : vel_reg;
    assign err_next    = cmd.vel_en ? (ERR_W'(target_reg) - ERR_W'(vel_sat)) : err_reg;

    // Increment accumulation
    always_comb
    begin
        case (cmd.sum_op)
            SUM_LOAD: sum_next = SUM_W'(prod_reg);
            SUM_ADD:  sum_next = sum_reg + SUM_W'(prod_reg);
            default:  sum_next = sum_reg;
        endcase
    end

    // Accumulator update with clamp
    assign inc     = sum_reg >>> COEF_FRAC_BITS;
    assign acc_sum = ACC_SUM_W'(acc_reg) + ACC_SUM_W'(inc);
    assign acc_hi  = ACC_SUM_W'(ACC_LIMIT);
    assign acc_lo  = -acc_hi;

    always_comb
    begin
        if (acc_sum > acc_hi)
            acc_clamped = acc_hi[ACC_W-1:0];
        else if (acc_sum < acc_lo)
            acc_clamped = acc_lo[ACC_W-1:0];
        else
            acc_clamped = acc_sum[ACC_W-1:0];
    end

    assign acc_next      = cmd.acc_en ? acc_clamped : acc_reg;
    assign err_prev_next = cmd.acc_en ? err_last_reg : err_prev_reg;
    assign err_last_next = cmd.acc_en ? err_reg : err_last_reg;

    // Drive: truncate toward zero
    assign acc_mag  = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
    assign duty_val = acc_mag[VEL_FRAC +: DUTY_W];
    assign drv_neg  = acc_reg[ACC_W-1] && (duty_val != '0);

    assign duty_next  = cmd.out_load ? duty_val : duty_reg;
    assign dir1_next  = cmd.out_load ? drv_neg : dir1_reg;
    assign dir2_next  = cmd.out_load ? !drv_neg : dir2_reg;
    assign drive_next = cmd.out_load ? (drv_neg ? -DRIVE_W'(duty_val) : DRIVE_W'(duty_val))
                                     : drive_reg;
    assign mvel_next  = cmd.out_load ? vel_reg : mvel_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            err_last_reg <= '0;
            err_prev_reg <= '0;
            acc_reg      <= '0;
        end
        else
        begin
            count_reg    <= count_next;
            err_last_reg <= err_last_next;
            err_prev_reg <= err_prev_next;
            acc_reg      <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        target_reg <= target_next;
        err_reg    <= err_next;
        vel_reg    <= vel_next;
        prod_reg   <= prod_next;
        sum_reg    <= sum_next;
        duty_reg   <= duty_next;
        dir1_reg   <= dir1_next;
        dir2_reg   <= dir2_next;
        drive_reg  <= drive_next;
        mvel_reg   <= mvel_next;
    end

    assign duty              = duty_reg;
    assign dir_in1           = dir1_reg;
    assign dir_in2           = dir2_reg;
    assign drive             = drive_reg;
    assign measured_velocity = mvel_reg;

    a_acc_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (ACC_SUM_W'(acc_reg) <= acc_hi) && (ACC_SUM_W'(acc_reg) >= acc_lo))
        else $error("drive accumulator outside its clamp range");

    a_count_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.vel_en |=> (count_reg == '0))
        else $error("edge count not cleared by tick");

    a_dir_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> (dir1_reg != dir2_reg))
        else $error("bridge direction pins not complementary");

endmodule

// ===== design/encoder_incremental_pid_speed_control_unit.sv =====
// Quadrature-encoder speed loop with an incremental PID. Each request on req_ch is either
// an encoder edge sample (req_type 0) or a control tick (req_type 1). An edge is counted
// in the cycle it is accepted: equal A/B levels count down, unequal levels count up
// (inverted when reverse_dir is set), and the count saturates at its signed bounds. A tick
// converts the count to a Q12.12 velocity with velocity_scale, clears the count, forms the
// error against the setpoint, adds floor((q0*e + q1*e_last + q2*e_before_last) >> 16) to
// the drive accumulator clamped to +-255.0, and returns one result on rsp_ch: duty, bridge
// pins and the signed drive truncated toward zero, plus the saturated measured velocity.
// Edges produce no result. Edges are taken whenever the block is idle; a tick holds off
// new requests until its result register has loaded, stepping through four products
// (velocity and three coefficient terms) in turn on one shared registered multiplier, then
// the accumulator clamp and the result load. A finished result waits in its own register,
// so edge requests keep flowing while it is pending; a second tick stalls in its last step
// until the first result is taken. Registers sit on the APB port at byte addresses
// 0 (coef_q0), 4 (coef_q1), 8 (coef_q2), 12 (velocity_scale) and 16 (reverse_dir); write
// them only while no tick is in flight. Configuration, edge count, error history and the
// accumulator reset to zero, the other registers do not; there is no start-up sweep.
module encoder_incremental_pid_speed_control_unit import epsc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    epsc_req_if.sink              req_ch,
    epsc_rsp_if.source            rsp_ch,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t    cfg;
    dp_cmd_t cmd;

    // Configuration registers
    epsc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Sequencer: accepts requests, steps the multiplier through its four products and
    // hands the result to the output register
    epsc_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (req_ch.valid),
        .in_req_type (req_ch.req_type),
        .in_ready    (req_ch.ready),
        .out_valid   (rsp_ch.valid),
        .out_ready   (rsp_ch.ready),
        .cmd         (cmd)
    );

    // Datapath: edge counter, shared multiplier, error history, accumulator and result
    epsc_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .cfg               (cfg),
        .enc_a             (req_ch.enc_a),
        .enc_b             (req_ch.enc_b),
        .setpoint          (req_ch.setpoint),
        .duty              (rsp_ch.duty),
        .dir_in1           (rsp_ch.dir_in1),
        .dir_in2           (rsp_ch.dir_in2),
        .drive             (rsp_ch.drive),
        .measured_velocity (rsp_ch.measured_velocity)
    );

endmodule
